>>> rtl/core/lkv_pkg.sv
// Shared constants and controller/datapath interface types for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int DATA_W          = 32;
    localparam int CFG_W           = 5;
    localparam int ENTRIES_DEFAULT = 16;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic update;
    } lkv_cmd_t;

    typedef struct packed {
        logic index_last;
        logic need_update;
    } lkv_stat_t;

endpackage

>>> rtl/core/lru_key_value_cache.sv
// Top level of the LRU key-value cache: configuration register, sequencer and datapath.
//
//  Channel   Handshake                      Payload
//  request   start, accepted when !busy     mode, key, write_value
//  result    done, one-cycle strobe         hit, read_value, evicted
//  config    APB write, pready tied high    paddr, pwdata, prdata
//
// A request makes one pass over the entry memories that compares keys and finds the oldest
// and first free entries, then a decision step, then a second pass that rewrites ages; a get
// that misses skips the second pass and ends after the decision step.
// Each pass reads one entry per cycle through the single read port of each memory.
// busy falls in the cycle that done is high, so the next request may start there.
// Reset clears all valid bits and the occupancy count; the receiver cannot stall results.
`timescale 1ns / 1ps

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    input  logic              mode,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] write_value,
    output logic              busy,
    output logic              done,
    output logic              hit,
    output logic [DATA_W-1:0] read_value,
    output logic              evicted
);

    logic [CFG_W-1:0] entries_reg;
    lkv_cmd_t         cmd;
    lkv_stat_t        stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2:2] == REG_ENTRIES_IN_USE))
        begin
            entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2:2] == REG_ENTRIES_IN_USE) ? {{(32-CFG_W){1'b0}}, entries_reg}
                                                        : '0;

    lkv_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    lkv_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .mode           (mode),
        .key            (key),
        .write_value    (write_value),
        .entries_in_use (entries_reg),
        .hit            (hit),
        .read_value     (read_value),
        .evicted        (evicted)
    );

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result strobe raised while a request is still in progress.");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("Accepted request did not raise busy.");

    assert property (@(posedge clk) disable iff (!rst_n) (done && evicted) |-> !hit)
        else $error("Eviction reported on a request that hit.");

    assert property (@(posedge clk) disable iff (!rst_n) (done && !hit) |-> (read_value == '0))
        else $error("Nonzero read value on a miss.");

endmodule

>>> rtl/core/lkv_ctrl.sv
// Request sequencer: scan pass, decision step, age update pass and result strobe.
`timescale 1ns / 1ps

module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lkv_stat_t stat,
    output lkv_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_UPD,
        S_UPD_END
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.load   = start && !busy_reg;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.decide = (state_reg == S_DECIDE);
        cmd.update = (state_reg == S_UPD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_SCAN;
                        busy_reg  <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (stat.index_last)
                    begin
                        state_reg <= S_SCAN_END;
                    end
                end
                S_SCAN_END:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (stat.need_update)
                    begin
                        state_reg <= S_UPD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                S_UPD:
                begin
                    if (stat.index_last)
                    begin
                        state_reg <= S_UPD_END;
                    end
                end
                S_UPD_END:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

>>> rtl/core/lkv_datapath.sv
// Entry storage, scan accumulators, replacement decision and age update for the cache.
`timescale 1ns / 1ps

module lkv_datapath
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lkv_cmd_t          cmd,
    output lkv_stat_t         stat,
    input  logic              mode,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] write_value,
    input  logic [CFG_W-1:0]  entries_in_use,
    output logic              hit,
    output logic [DATA_W-1:0] read_value,
    output logic              evicted
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W = IDX_W;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    logic [DATA_W-1:0] key_mem [ENTRIES];
    logic [DATA_W-1:0] val_mem [ENTRIES];
    logic [AGE_W-1:0]  age_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   count_reg;

    logic              mode_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] wval_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic              pipe_scan_reg;
    logic              pipe_upd_reg;
    logic [DATA_W-1:0] key_q;
    logic [DATA_W-1:0] val_q;
    logic [AGE_W-1:0]  age_q;
    logic              vld_q;

    logic              found_reg;
    logic [IDX_W-1:0]  found_idx_reg;
    logic [AGE_W-1:0]  found_age_reg;
    logic [DATA_W-1:0] found_val_reg;
    logic              old_seen_reg;
    logic [IDX_W-1:0]  old_idx_reg;
    logic [AGE_W-1:0]  old_age_reg;
    logic              free_seen_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    logic [IDX_W-1:0]  target_reg;
    logic              miss_put_reg;
    logic              hit_reg;
    logic              evict_reg;
    logic [DATA_W-1:0] rdata_reg;

    logic [CMP_W-1:0]  cap_raw;
    logic [CMP_W-1:0]  cap_eff;
    logic              full;
    logic              is_put;
    logic              miss_put;
    logic [IDX_W-1:0]  slot;
    logic              is_target;
    logic              age_inc;
    logic              age_we;
    logic [AGE_W-1:0]  age_wd;

    always_comb
    begin
        cap_raw = CMP_W'(entries_in_use);
        if (cap_raw == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_raw > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = cap_raw;
        end
        full     = (CMP_W'(count_reg) >= cap_eff);
        is_put   = (mode_reg == MODE_PUT);
        miss_put = is_put && !found_reg;
        if (found_reg)
        begin
            slot = found_idx_reg;
        end
        else if (full)
        begin
            slot = old_idx_reg;
        end
        else
        begin
            slot = free_idx_reg;
        end
        is_target = (pipe_idx_reg == target_reg);
        age_inc   = vld_q && !is_target && (miss_put_reg || (age_q < found_age_reg));
        age_we    = pipe_upd_reg && (is_target || age_inc);
        age_wd    = is_target ? '0 : age_q + AGE_W'(1);
    end

    assign stat.index_last  = (idx_reg == IDX_LAST);
    assign stat.need_update = found_reg || is_put;

    always_ff @(posedge clk)
    begin
        key_q <= key_mem[idx_reg];
        if (cmd.decide && miss_put)
        begin
            key_mem[slot] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_q <= val_mem[idx_reg];
        if (cmd.decide && is_put)
        begin
            val_mem[slot] <= wval_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        age_q <= age_mem[idx_reg];
        if (age_we)
        begin
            age_mem[pipe_idx_reg] <= age_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            key_reg  <= key;
            wval_reg <= write_value;
        end
        pipe_idx_reg <= idx_reg;
        if (cmd.decide)
        begin
            target_reg   <= slot;
            miss_put_reg <= miss_put;
            rdata_reg    <= (found_reg && !is_put) ? found_val_reg : '0;
        end
        if (pipe_scan_reg && vld_q && !found_reg && (key_q == key_reg))
        begin
            found_idx_reg <= pipe_idx_reg;
            found_age_reg <= age_q;
            found_val_reg <= val_q;
        end
        if (pipe_scan_reg && vld_q && (!old_seen_reg || (age_q > old_age_reg)))
        begin
            old_idx_reg <= pipe_idx_reg;
            old_age_reg <= age_q;
        end
        if (pipe_scan_reg && !vld_q && !free_seen_reg)
        begin
            free_idx_reg <= pipe_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            pipe_scan_reg <= 1'b0;
            pipe_upd_reg  <= 1'b0;
            vld_q         <= 1'b0;
            found_reg     <= 1'b0;
            old_seen_reg  <= 1'b0;
            free_seen_reg <= 1'b0;
            hit_reg       <= 1'b0;
            evict_reg     <= 1'b0;
        end
        else
        begin
            pipe_scan_reg <= cmd.scan;
            pipe_upd_reg  <= cmd.update;
            vld_q         <= valid_reg[idx_reg];
            if (cmd.load || cmd.decide)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan || cmd.update)
            begin
                idx_reg <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.load)
            begin
                found_reg     <= 1'b0;
                old_seen_reg  <= 1'b0;
                free_seen_reg <= 1'b0;
            end
            else if (pipe_scan_reg)
            begin
                if (vld_q && (key_q == key_reg))
                begin
                    found_reg <= 1'b1;
                end
                if (vld_q)
                begin
                    old_seen_reg <= 1'b1;
                end
                if (!vld_q)
                begin
                    free_seen_reg <= 1'b1;
                end
            end
            if (cmd.decide)
            begin
                hit_reg   <= found_reg;
                evict_reg <= miss_put && full;
                if (miss_put)
                begin
                    valid_reg[slot] <= 1'b1;
                    if (!full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign hit        = hit_reg;
    assign read_value = rdata_reg;
    assign evicted    = evict_reg;

endmodule

>>> dv/lru_key_value_cache_checker.sv
// Checker for the LRU key-value cache: tracks the capacity register, predicts each response.
`timescale 1ns / 1ps

module lru_key_value_cache_checker
    import lkv_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              start,
    input  logic              busy,
    input  logic              mode,
    input  logic [DATA_W-1:0] key,
    input  logic [DATA_W-1:0] write_value,
    input  logic              done,
    input  logic              hit,
    input  logic [DATA_W-1:0] read_value,
    input  logic              evicted,
    output int                errors,
    output int                pending
);

    localparam logic [2:0] CAP_ADDR = {REG_ENTRIES_IN_USE, 2'b00};

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
    } cache_outcome_t;

    logic [DATA_W-1:0] slot_key   [ENTRIES];
    logic [DATA_W-1:0] slot_value [ENTRIES];
    logic              slot_valid [ENTRIES];
    int                slot_age   [ENTRIES];
    int                occupancy;
    logic [CFG_W-1:0]  capacity;

    cache_outcome_t expected_outcomes[$];

    function automatic cache_outcome_t cache_access(logic op, logic [DATA_W-1:0] k,
                                                    logic [DATA_W-1:0] v);
        cache_outcome_t res;
        int found;
        int slot;
        int limit;
        int oldest;
        int rank;
        res = '0;
        found = -1;
        slot = -1;
        oldest = 0;
        limit = capacity;
        if (limit < 1)
            limit = 1;
        if (limit > ENTRIES)
            limit = ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (found < 0 && slot_valid[i] && slot_key[i] == k)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit = 1'b1;
            if (op == MODE_GET)
                res.read_value = slot_value[found];
            else
                slot_value[found] = v;
            rank = slot_age[found];
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_valid[i] && slot_age[i] < rank)
                    slot_age[i]++;
            end
            slot_age[found] = 0;
        end
        else if (op == MODE_PUT)
        begin
            if (occupancy >= limit)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i] && (slot < 0 || slot_age[i] > oldest))
                    begin
                        oldest = slot_age[i];
                        slot = i;
                    end
                end
                if (slot >= 0)
                begin
                    slot_valid[slot] = 1'b0;
                    occupancy--;
                    res.evicted = 1'b1;
                end
            end
            if (slot < 0)
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!slot_valid[i])
                        slot = i;
                end
            end
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_valid[i])
                        slot_age[i]++;
                end
                slot_key[slot] = k;
                slot_value[slot] = v;
                slot_valid[slot] = 1'b1;
                slot_age[slot] = 0;
                occupancy++;
            end
        end
        return res;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        cache_outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_key[i] = '0;
                slot_value[i] = '0;
                slot_valid[i] = 1'b0;
                slot_age[i] = 0;
            end
            occupancy = 0;
            capacity = CAP_RESET;
            expected_outcomes.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                capacity = pwdata[CFG_W-1:0];
            if (done)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: response with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                        errors++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, read_value);
                        errors++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $display("%0t: evicted expected %0b actual %0b", $time,
                                 want.evicted, evicted);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_outcomes.push_back(cache_access(mode, key, write_value));
        end
        pending = expected_outcomes.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for the LRU key-value cache: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module tb;
    import lkv_pkg::*;

    localparam int ENTRIES = ENTRIES_DEFAULT;
    localparam logic [2:0] CAP_ADDR = {REG_ENTRIES_IN_USE, 2'b00};
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 138;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              start;
    logic              mode;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] write_value;
    logic              busy;
    logic              done;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    int                errors;
    int                pending;

    logic [DATA_W-1:0] key_pool[40];
    int                pool_size;
    logic              burst;

    lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .mode(mode), .key(key), .write_value(write_value),
        .busy(busy), .done(done), .hit(hit), .read_value(read_value), .evicted(evicted)
    );

    lru_key_value_cache_checker #(.ENTRIES(ENTRIES)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .start(start), .busy(busy), .mode(mode), .key(key), .write_value(write_value),
        .done(done), .hit(hit), .read_value(read_value), .evicted(evicted),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge where the next request may be set up.
    task automatic issue_request(logic op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 12);
        start <= 1'b1;
        mode <= op;
        key <= k;
        write_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (2 * ENTRIES + 8) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] cap);
        logic [31:0] word;
        word = $urandom;
        word[CFG_W-1:0] = cap;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAP_ADDR;
        pwdata <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return $urandom;
        if (r < 10)
            return (r == 8) ? 32'h0000_0000 : 32'hFFFF_FFFF;
        return key_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    initial
    begin
        logic [CFG_W-1:0] caps[PHASES];
        int limit;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        mode = MODE_GET;
        key = '0;
        write_value = '0;
        burst = 1'b0;
        pool_size = 1;
        caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd16, 5'd3, 5'd8, 5'd16};
        caps[8] = CFG_W'($urandom_range(0, 31));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue_request(MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_request(MODE_PUT, 32'h0000_0000, 32'h0000_0000);
        issue_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_request(MODE_GET, 32'h0000_0000, 32'h1234_5678);
        issue_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_request(MODE_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
        issue_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        issue_request(MODE_GET, 32'h1234_5678, 32'h0000_0000);
        issue_request(MODE_PUT, 32'h0000_0001, 32'h0000_0001);
        issue_request(MODE_PUT, 32'h0000_0002, 32'h5A5A_5A5A);
        drain();
        // Capacity zero behaves as one and is already below the occupancy.
        write_capacity(5'd0);
        issue_request(MODE_PUT, 32'h0000_0003, 32'h0000_0003);
        issue_request(MODE_GET, 32'h0000_0003, 32'h0000_0000);
        issue_request(MODE_PUT, 32'h0000_0004, 32'h0000_0004);
        issue_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
        drain();
        write_capacity(5'd31);
        issue_request(MODE_PUT, 32'h0000_0005, 32'h0000_0005);
        issue_request(MODE_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        drain();
        write_capacity(5'd2);
        issue_request(MODE_PUT, 32'h0000_0006, 32'h0000_0006);
        issue_request(MODE_GET, 32'h0000_0004, 32'h0000_0000);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_capacity(caps[p]);
            limit = caps[p];
            if (limit < 1)
                limit = 1;
            if (limit > ENTRIES)
                limit = ENTRIES;
            pool_size = limit + $urandom_range(1, limit + 2);
            for (int i = 0; i < pool_size; i++)
                key_pool[i] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 29) == 0)
                    burst = ~burst;
                if ($urandom_range(0, 59) == 0)
                    drain();
                issue_request($urandom_range(0, 1) ? MODE_PUT : MODE_GET, pick_key(),
                              pick_value());
            end
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
